### rtl/core/ultrasonic_echo_range_averager_macros.svh
// Assertion macros for the echo range averager checker.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ULTRASONIC_ECHO_RANGE_AVERAGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGE_AVERAGER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UERA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uera assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define UERA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uera assertion failed");

`endif

### rtl/core/uera_pkg.sv
// ----------------------------------------------------------------------------
// uera_pkg: shared definitions for the echo range averager
// Sequencer states, register indexes, reset values and datapath widths.
// ----------------------------------------------------------------------------
package uera_pkg;

  localparam int ALU_W = 34;

  typedef logic [ALU_W-1:0] alu_word_t;
  typedef logic [2:0]       reg_index_t;
  typedef logic [3:0]       step_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_MUL,
    ST_DIV,
    ST_RESULT
  } state_t;

  // Shift-add multiply runs one multiplier bit per step, restoring divide
  // produces one quotient bit per step (bit 8 flags a quotient of 256 or more).
  localparam step_t MUL_LAST = 4'd7;
  localparam step_t DIV_LAST = 4'd8;

  localparam reg_index_t REG_AVG_LEN      = 3'd0;
  localparam reg_index_t REG_MAX_ECHO     = 3'd1;
  localparam reg_index_t REG_RANGE_LIMIT  = 3'd2;
  localparam reg_index_t REG_US_PER_CM    = 3'd3;
  localparam reg_index_t REG_UNDEF_CODE   = 3'd4;

  localparam logic [7:0]  RST_AVG_LEN      = 8'd5;
  localparam logic [15:0] RST_MAX_ECHO     = 16'd30000;
  localparam logic [7:0]  RST_RANGE_LIMIT  = 8'd200;
  localparam logic [15:0] RST_US_PER_CM    = 16'd7450;
  localparam logic [7:0]  RST_UNDEF_CODE   = 8'd255;

endpackage

### rtl/core/uera_alu.sv
// ----------------------------------------------------------------------------
// uera_alu: shared adder/subtractor
// One wide add or subtract used for accumulation, multiply and divide steps.
// ----------------------------------------------------------------------------
module uera_alu (
  input  uera_pkg::alu_word_t a,
  input  uera_pkg::alu_word_t b,
  input  logic                sub,
  output uera_pkg::alu_word_t res
);
  import uera_pkg::*;

  alu_word_t b_eff;

  assign b_eff = sub ? ~b : b;
  assign res   = a + b_eff + {{(ALU_W-1){1'b0}}, sub};

endmodule

### rtl/core/ultrasonic_echo_range_averager.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_range_averager: averaged echo-to-distance converter
//
// Input channel (in_valid/in_ready, echo_us) takes one echo width in
// microseconds per beat. Echoes above zero and below max_echo are summed
// and counted. After avg_len beats one result beat leaves on the output
// channel (out_valid/out_ready, distance_cm, valid_res).
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data) that the
// user must write only while the block is idle; the block does not enforce it.
//
// Sequencing: every input beat is accepted and then takes one accumulate step
// through the shared adder. A beat that closes an average then runs an 8-step
// shift-add multiply and a 9-step restoring divide on the same adder, skipped
// if the count or us_per_cm is zero, before its result is registered.
// The output is a register, so the next echo is taken while a result waits;
// if a new result is ready while the old one is still stalled, the sequencer
// holds in its result state until the output register frees up.
// Reset (synchronous, rst) restores the register defaults, clears the
// accumulators and empties the output register.
// ----------------------------------------------------------------------------
module ultrasonic_echo_range_averager (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] echo_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  distance_cm,
  output logic        valid_res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import uera_pkg::*;

  // Configuration
  logic [7:0]  avg_len;
  logic [15:0] max_echo;
  logic [7:0]  range_limit;
  logic [15:0] us_per_cm_q8;
  logic [7:0]  undef_code;

  // Accumulators
  logic [23:0] echo_sum;
  logic [7:0]  valid_count;
  logic [7:0]  repeat_count;

  // Sequencer and datapath
  state_t      state;
  state_t      state_next;
  step_t       step;
  logic [15:0] echo_reg;
  logic [23:0] mcand;
  logic [7:0]  mplier;
  logic [23:0] prod;
  logic [31:0] rem;
  logic [32:0] dsh;
  logic [8:0]  quot;
  logic        undef;

  alu_word_t   alu_a;
  alu_word_t   alu_b;
  logic        alu_sub;
  alu_word_t   alu_res;

  logic        echo_ok;
  logic [7:0]  valid_inc;
  logic [7:0]  repeat_inc;
  logic [23:0] sum_new;
  logic [7:0]  count_new;
  logic        emit;
  logic        skip_div;
  logic [23:0] prod_new;
  logic        ge;
  logic        out_free;
  logic        dist_ok;

  uera_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res)
  );

  assign echo_ok    = (echo_reg != 16'd0) && (echo_reg < max_echo);
  assign valid_inc  = valid_count + 8'd1;
  assign repeat_inc = repeat_count + 8'd1;
  assign sum_new    = echo_ok ? alu_res[23:0] : echo_sum;
  assign count_new  = echo_ok ? valid_inc : valid_count;
  assign emit       = !(repeat_inc < avg_len);
  assign skip_div   = (count_new == 8'd0) || (us_per_cm_q8 == 16'd0);
  assign prod_new   = mplier[0] ? alu_res[23:0] : prod;
  // Both operands are below 2^33, so the top bit is the borrow.
  assign ge         = !alu_res[ALU_W-1];
  assign out_free   = !out_valid || out_ready;
  assign dist_ok    = !undef && !quot[8] && (quot[7:0] != 8'd0)
                      && (quot[7:0] < range_limit);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_ACC;
      end
      ST_ACC: begin
        if (!emit) state_next = ST_IDLE;
        else if (skip_div) state_next = ST_RESULT;
        else state_next = ST_MUL;
      end
      ST_MUL: begin
        if (step == MUL_LAST) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (step == DIV_LAST) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and shared adder operands
  always_comb begin
    in_ready = 1'b0;
    alu_a    = '0;
    alu_b    = '0;
    alu_sub  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_ACC: begin
        alu_a = {{(ALU_W-24){1'b0}}, echo_sum};
        alu_b = {{(ALU_W-16){1'b0}}, echo_reg};
      end
      ST_MUL: begin
        alu_a = {{(ALU_W-24){1'b0}}, prod};
        alu_b = {{(ALU_W-24){1'b0}}, mcand};
      end
      ST_DIV: begin
        alu_a   = {{(ALU_W-32){1'b0}}, rem};
        alu_b   = {{(ALU_W-33){1'b0}}, dsh};
        alu_sub = 1'b1;
      end
      ST_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      avg_len      <= RST_AVG_LEN;
      max_echo     <= RST_MAX_ECHO;
      range_limit  <= RST_RANGE_LIMIT;
      us_per_cm_q8 <= RST_US_PER_CM;
      undef_code   <= RST_UNDEF_CODE;
      echo_sum     <= '0;
      valid_count  <= '0;
      repeat_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_AVG_LEN:      avg_len      <= cfg_data[7:0];
          REG_MAX_ECHO:     max_echo     <= cfg_data;
          REG_RANGE_LIMIT:  range_limit  <= cfg_data[7:0];
          REG_US_PER_CM:    us_per_cm_q8 <= cfg_data;
          REG_UNDEF_CODE:   undef_code   <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
      if (state == ST_ACC) begin
        if (emit) begin
          echo_sum     <= '0;
          valid_count  <= '0;
          repeat_count <= '0;
        end else begin
          echo_sum     <= sum_new;
          valid_count  <= count_new;
          repeat_count <= repeat_inc;
        end
      end
      if (state == ST_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        echo_reg <= echo_us;
      end
      ST_ACC: begin
        mcand  <= {8'd0, us_per_cm_q8};
        mplier <= count_new;
        prod   <= '0;
        rem    <= {sum_new, 8'd0};
        step   <= '0;
        undef  <= skip_div;
      end
      ST_MUL: begin
        prod   <= prod_new;
        mcand  <= {mcand[22:0], 1'b0};
        mplier <= {1'b0, mplier[7:1]};
        if (step == MUL_LAST) begin
          // Divisor is 2*us_per_cm*count, aligned for the first quotient bit.
          dsh  <= {prod_new, 9'd0};
          quot <= '0;
          step <= '0;
        end else begin
          step <= step + 4'd1;
        end
      end
      ST_DIV: begin
        if (ge) rem <= alu_res[31:0];
        quot <= {quot[7:0], ge};
        dsh  <= {1'b0, dsh[32:1]};
        step <= step + 4'd1;
      end
      ST_RESULT: begin
        if (out_free) begin
          distance_cm <= dist_ok ? quot[7:0] : undef_code;
          valid_res   <= dist_ok;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/uera_checker.sv
// ----------------------------------------------------------------------------
// uera_checker: port-level checks for the echo range averager
// Watches the handshakes and result fields of the top level over time.
// ----------------------------------------------------------------------------
`include "ultrasonic_echo_range_averager_macros.svh"

module uera_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  distance_cm,
  input logic        valid_res
);

  // A stalled result beat stays put with its payload.
  `UERA_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(distance_cm) && $stable(valid_res))

  // The sequencer is busy in the cycle after taking an echo.
  `UERA_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // A new result is only produced while the sequencer is busy.
  `UERA_ASSERT_IMP(a_result_from_busy, $rose(out_valid), $past(!in_ready))

  // A reported measurement is never zero.
  `UERA_ASSERT_IMP(a_valid_nonzero, out_valid && valid_res, distance_cm != 8'd0)

endmodule

bind ultrasonic_echo_range_averager uera_checker u_uera_checker (.*);
